// File: hdl/pcint_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcint_pkg
// Shared types, codes and helpers of the particle predict/clamp/integrate
// datapath.
// ----------------------------------------------------------------------------
package pcint_pkg;

  typedef enum logic [1:0] {
    KindPredict   = 2'd0,
    KindClamp     = 2'd1,
    KindIntegrate = 2'd2,
    KindReserved  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CfgStepTime   = 3'd0,
    CfgStepRate   = 3'd1,
    CfgGravityY   = 3'd2,
    CfgGround     = 3'd3,
    CfgLeftWall   = 3'd4,
    CfgRightWall  = 3'd5,
    CfgFrontWall  = 3'd6,
    CfgBackWall   = 3'd7
  } cfg_idx_e;

  localparam int unsigned NumLanes = 3;
  localparam int unsigned Stages   = 6;

  // 0.99 in Q16.16, and 1.0 to pass a value through the damping multiply
  localparam logic [16:0] DampQ16  = 17'd64881;
  localparam logic [16:0] UnityQ16 = 17'd65536;

  localparam logic [16:0] StepTimeRst = 17'd1092;
  localparam logic [30:0] StepRateRst = 31'd3932160;
  localparam logic [31:0] GravityRst  = 32'hFFF6_30A4;
  localparam logic [31:0] GroundRst   = 32'h0000_0000;
  localparam logic [31:0] LeftRst     = 32'hFFF6_0000;
  localparam logic [31:0] RightRst    = 32'h000A_0000;
  localparam logic [31:0] FrontRst    = 32'h000A_0000;
  localparam logic [31:0] BackRst     = 32'hFFF6_0000;

  // saturate a wide signed value to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if ((v[49:31] == '0) || (v[49:31] == '1)) begin
      r = v[31:0];
    end else if (v[49]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// File: hdl/particle_predict_clamp_integrate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_predict_clamp_integrate
// Position-based-dynamics particle update in signed Q16.16 with saturation:
// predict, clamp to ground and walls, or integrate, selected per transaction.
// ----------------------------------------------------------------------------
// channel   direction  tdata fields (low to high)                 tuser
// s_axis    in         pos_x/y/z, aux_x/y/z, force_x/y/z, inv_mass kind
// m_axis    out        out_x/y/z, vel_x/y/z                       -
// cfg       in         cfg_idx_i selects register, cfg_data_i     -
//
// Six register stages: operand prep, Q16 product, sum and saturate, damping
// product, step_time product, final sum. One transaction enters per cycle
// while s_axis_tready is high. Each stage loads whenever it is empty or the
// next stage moves, so bubbles collapse under back-pressure. Reset clears the
// valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module particle_predict_clamp_integrate (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, aux_x, aux_y, aux_z, force_x, force_y, force_z,
  // inv_mass[30:0], one zero pad bit
  input  logic [319:0] s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z, vel_x, vel_y, vel_z
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned NL = pcint_pkg::NumLanes;
  localparam int unsigned NS = pcint_pkg::Stages;

  // configuration registers
  logic        [16:0] step_time_q;
  logic        [30:0] step_rate_q;
  logic signed [31:0] gravity_q, ground_q, left_q, right_q, front_q, back_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q <= pcint_pkg::StepTimeRst;
      step_rate_q <= pcint_pkg::StepRateRst;
      gravity_q   <= pcint_pkg::GravityRst;
      ground_q    <= pcint_pkg::GroundRst;
      left_q      <= pcint_pkg::LeftRst;
      right_q     <= pcint_pkg::RightRst;
      front_q     <= pcint_pkg::FrontRst;
      back_q      <= pcint_pkg::BackRst;
    end else if (cfg_we_i) begin
      unique case (pcint_pkg::cfg_idx_e'(cfg_idx_i))
        pcint_pkg::CfgStepTime:  step_time_q <= cfg_data_i[16:0];
        pcint_pkg::CfgStepRate:  step_rate_q <= cfg_data_i[30:0];
        pcint_pkg::CfgGravityY:  gravity_q   <= cfg_data_i;
        pcint_pkg::CfgGround:    ground_q    <= cfg_data_i;
        pcint_pkg::CfgLeftWall:  left_q      <= cfg_data_i;
        pcint_pkg::CfgRightWall: right_q     <= cfg_data_i;
        pcint_pkg::CfgFrontWall: front_q     <= cfg_data_i;
        pcint_pkg::CfgBackWall:  back_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid chain and per-stage load enables
  logic [NS-1:0] v_q, v_d, en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || m_axis_tready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign s_axis_tready = en[0];

  always_comb begin
    v_d[0] = en[0] ? s_axis_tvalid : v_q[0];
    for (int s = 1; s < NS; s++) begin
      if (en[s]) begin
        v_d[s] = v_q[s-1];
      end else begin
        v_d[s] = v_q[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // ---------------- stage 1: operand prep, clamp ----------------
  pcint_pkg::kind_e   in_kind;
  logic signed [31:0] in_pos [NL];
  logic signed [31:0] in_aux [NL];
  logic signed [31:0] in_frc [NL];
  logic        [30:0] in_imass;
  logic        [47:0] kprod;
  logic        [30:0] kval;
  logic signed [32:0] asum   [NL];
  logic signed [32:0] dsum   [NL];
  logic signed [31:0] aval   [NL];
  logic signed [31:0] clamp  [NL];
  logic signed [31:0] gsel   [NL];

  assign in_kind  = pcint_pkg::kind_e'(s_axis_tuser);
  assign in_imass = s_axis_tdata[318:288];
  assign kprod    = {31'd0, step_time_q} * {17'd0, in_imass};
  assign kval     = kprod[47] ? 31'h7FFF_FFFF : kprod[46:16];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      in_pos[i] = s_axis_tdata[32*i +: 32];
      in_aux[i] = s_axis_tdata[32*(i+3) +: 32];
      in_frc[i] = s_axis_tdata[32*(i+6) +: 32];
      gsel[i]   = (i == 1) ? gravity_q : 32'sd0;
      asum[i]   = {in_frc[i][31], in_frc[i]} + {gsel[i][31], gsel[i]};
      aval[i]   = pcint_pkg::sat32({{17{asum[i][32]}}, asum[i]});
      dsum[i]   = {in_aux[i][31], in_aux[i]} - {in_pos[i][31], in_pos[i]};
    end
    clamp[0] = in_pos[0];
    if (clamp[0] < left_q)  clamp[0] = left_q;
    if (clamp[0] > right_q) clamp[0] = right_q;
    clamp[1] = (in_pos[1] < ground_q) ? ground_q : in_pos[1];
    clamp[2] = in_pos[2];
    if (clamp[2] > front_q) clamp[2] = front_q;
    if (clamp[2] < back_q)  clamp[2] = back_q;
  end

  pcint_pkg::kind_e   s1_kind_q;
  logic signed [31:0] s1_pos_q  [NL];
  logic signed [31:0] s1_aux_q  [NL];
  logic        [30:0] s1_mula_q;
  logic signed [32:0] s1_mulb_q [NL];
  logic        [16:0] s1_damp_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_kind_q <= in_kind;
      s1_mula_q <= (in_kind == pcint_pkg::KindPredict) ? kval : step_rate_q;
      s1_damp_q <= (in_kind == pcint_pkg::KindPredict) ? pcint_pkg::DampQ16
                                                       : pcint_pkg::UnityQ16;
      for (int i = 0; i < NL; i++) begin
        s1_pos_q[i]  <= (in_kind == pcint_pkg::KindClamp) ? clamp[i] : in_pos[i];
        s1_aux_q[i]  <= in_aux[i];
        s1_mulb_q[i] <= (in_kind == pcint_pkg::KindPredict) ?
                        {aval[i][31], aval[i]} : dsum[i];
      end
    end
  end

  // ---------------- stage 2: k*a or d*step_rate ----------------
  logic signed [64:0] mprod [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      mprod[i] = $signed({1'b0, s1_mula_q}) * s1_mulb_q[i];
    end
  end

  pcint_pkg::kind_e   s2_kind_q;
  logic signed [31:0] s2_pos_q  [NL];
  logic signed [31:0] s2_aux_q  [NL];
  logic signed [64:0] s2_prod_q [NL];
  logic        [16:0] s2_damp_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_kind_q <= s1_kind_q;
      s2_damp_q <= s1_damp_q;
      for (int i = 0; i < NL; i++) begin
        s2_pos_q[i]  <= s1_pos_q[i];
        s2_aux_q[i]  <= s1_aux_q[i];
        s2_prod_q[i] <= mprod[i];
      end
    end
  end

  // ---------------- stage 3: add velocity, saturate ----------------
  logic signed [49:0] wsum [NL];
  logic signed [49:0] addend [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      addend[i] = (s2_kind_q == pcint_pkg::KindPredict) ?
                  {{18{s2_aux_q[i][31]}}, s2_aux_q[i]} : 50'sd0;
      wsum[i]   = {s2_prod_q[i][64], s2_prod_q[i][64:16]} + addend[i];
    end
  end

  pcint_pkg::kind_e   s3_kind_q;
  logic signed [31:0] s3_pos_q [NL];
  logic signed [31:0] s3_aux_q [NL];
  logic signed [31:0] s3_w_q   [NL];
  logic        [16:0] s3_damp_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_kind_q <= s2_kind_q;
      s3_damp_q <= s2_damp_q;
      for (int i = 0; i < NL; i++) begin
        s3_pos_q[i] <= s2_pos_q[i];
        s3_aux_q[i] <= s2_aux_q[i];
        s3_w_q[i]   <= pcint_pkg::sat32(wsum[i]);
      end
    end
  end

  // ---------------- stage 4: damping product ----------------
  logic signed [49:0] dprod [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      dprod[i] = s3_w_q[i] * $signed({1'b0, s3_damp_q});
    end
  end

  pcint_pkg::kind_e   s4_kind_q;
  logic signed [31:0] s4_pos_q  [NL];
  logic signed [31:0] s4_aux_q  [NL];
  logic signed [49:0] s4_prod_q [NL];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_kind_q <= s3_kind_q;
      for (int i = 0; i < NL; i++) begin
        s4_pos_q[i]  <= s3_pos_q[i];
        s4_aux_q[i]  <= s3_aux_q[i];
        s4_prod_q[i] <= dprod[i];
      end
    end
  end

  // ---------------- stage 5: velocity times step_time ----------------
  logic signed [31:0] vel  [NL];
  logic signed [49:0] tprod [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      vel[i]   = s4_prod_q[i][47:16];
      tprod[i] = vel[i] * $signed({1'b0, step_time_q});
    end
  end

  pcint_pkg::kind_e   s5_kind_q;
  logic signed [31:0] s5_pos_q  [NL];
  logic signed [31:0] s5_aux_q  [NL];
  logic signed [31:0] s5_vel_q  [NL];
  logic signed [49:0] s5_prod_q [NL];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_kind_q <= s4_kind_q;
      for (int i = 0; i < NL; i++) begin
        s5_pos_q[i]  <= s4_pos_q[i];
        s5_aux_q[i]  <= s4_aux_q[i];
        s5_vel_q[i]  <= vel[i];
        s5_prod_q[i] <= tprod[i];
      end
    end
  end

  // ---------------- stage 6: position update, result select ----------------
  logic signed [49:0] psum  [NL];
  logic signed [31:0] res_o [NL];
  logic signed [31:0] res_v [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      psum[i] = {{16{s5_prod_q[i][49]}}, s5_prod_q[i][49:16]}
              + {{18{s5_pos_q[i][31]}}, s5_pos_q[i]};
      case (s5_kind_q)
        pcint_pkg::KindPredict, pcint_pkg::KindIntegrate: begin
          res_o[i] = pcint_pkg::sat32(psum[i]);
          res_v[i] = s5_vel_q[i];
        end
        pcint_pkg::KindClamp: begin
          res_o[i] = s5_pos_q[i];
          res_v[i] = s5_aux_q[i];
        end
        default: begin
          res_o[i] = '0;
          res_v[i] = '0;
        end
      endcase
    end
  end

  logic [191:0]     out_data_q;
  pcint_pkg::kind_e out_kind_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      out_kind_q <= s5_kind_q;
      for (int i = 0; i < NL; i++) begin
        out_data_q[32*i +: 32]     <= res_o[i];
        out_data_q[32*(i+3) +: 32] <= res_v[i];
      end
    end
  end

  assign m_axis_tvalid = v_q[NS-1];
  assign m_axis_tdata  = out_data_q;

  // ---------------- assertions ----------------
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v_q == '1))
    else $error("input stalled while a stage is empty");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted transaction not captured in first stage");

  a_reserved_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_kind_q == pcint_pkg::KindReserved)) |->
    (m_axis_tdata == '0))
    else $error("reserved kind produced nonzero result");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-2] && !en[NS-2]) |=> v_q[NS-2])
    else $error("stalled stage dropped its transaction");

endmodule
